// File: rtl/wft_pkg.sv
// Shared types and constants of the wall-follow turn controller.
package wft_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_POSE  = 2'd0,
    REQ_RANGE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_FRONT_CLEAR = 3'd0;
  localparam logic [2:0] CFG_SIDE_MARGIN = 3'd1;
  localparam logic [2:0] CFG_LEG_LENGTH  = 3'd2;
  localparam logic [2:0] CFG_CRUISE      = 3'd3;
  localparam logic [2:0] CFG_TURN_RATE   = 3'd4;
  localparam logic [2:0] CFG_DEADBAND    = 3'd5;
  localparam logic [2:0] CFG_CORR_LIMIT  = 3'd6;
  localparam logic [2:0] CFG_GAIN        = 3'd7;

  // Register reset values
  localparam logic [15:0] FRONT_CLEAR_RST = 16'd450;
  localparam logic [15:0] SIDE_MARGIN_RST = 16'd200;
  localparam logic [31:0] LEG_SQ_RST      = 32'd90000;  // 300 mm squared
  localparam logic [9:0]  CRUISE_RST      = 10'd200;
  localparam logic [9:0]  TURN_RATE_RST   = 10'd250;
  localparam logic [13:0] DEADBAND_RST    = 14'd364;
  localparam logic [9:0]  CORR_LIMIT_RST  = 10'd150;
  localparam logic [15:0] GAIN_RST        = 16'd1885;

  // Range reset and binary-angle constants
  localparam logic [15:0]        RANGE_RST    = 16'd10000;
  localparam logic signed [15:0] QUARTER      = 16'sd16384;
  localparam logic signed [15:0] NEG_QUARTER  = -16'sd16384;
  localparam logic [13:0]        EIGHTH       = 14'd8192;
  localparam logic [14:0]        QUARTER_MAG  = 15'd16384;
  localparam logic [30:0]        ROUND_HALF   = 31'd32768;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [15:0] front_clear;
    logic [15:0] side_margin;
    logic [31:0] leg_sq;
    logic [9:0]  cruise_speed;
    logic [9:0]  turn_rate;
    logic [13:0] deadband;
    logic [9:0]  corr_limit;
    logic [15:0] gain;
  } cfg_t;

  // One input item
  typedef struct packed {
    req_e               req;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] yaw;
    logic [15:0]        front;
    logic [15:0]        right;
    logic [15:0]        left;
  } item_t;

  // One drive command
  typedef struct packed {
    logic [9:0]         linear_speed;
    logic signed [10:0] angular_rate;
    logic [1:0]         drive_mode;
  } res_t;

  // Heading error to the nearest quadrant, sign and magnitude
  typedef struct packed {
    logic        neg;
    logic [13:0] mag;
  } herr_t;

endpackage

// File: rtl/wft_cfg_regs.sv
// Configuration register file with the squared leg length kept ready.
module wft_cfg_regs
  import wft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t        cfg_q;
  logic [31:0] leg_sq_d;

  // Leg length is only ever used squared
  assign leg_sq_d = {16'b0, cfg_data_i} * {16'b0, cfg_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_clear  <= FRONT_CLEAR_RST;
      cfg_q.side_margin  <= SIDE_MARGIN_RST;
      cfg_q.leg_sq       <= LEG_SQ_RST;
      cfg_q.cruise_speed <= CRUISE_RST;
      cfg_q.turn_rate    <= TURN_RATE_RST;
      cfg_q.deadband     <= DEADBAND_RST;
      cfg_q.corr_limit   <= CORR_LIMIT_RST;
      cfg_q.gain         <= GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRONT_CLEAR: cfg_q.front_clear  <= cfg_data_i;
        CFG_SIDE_MARGIN: cfg_q.side_margin  <= cfg_data_i;
        CFG_LEG_LENGTH:  cfg_q.leg_sq       <= leg_sq_d;
        CFG_CRUISE:      cfg_q.cruise_speed <= cfg_data_i[9:0];
        CFG_TURN_RATE:   cfg_q.turn_rate    <= cfg_data_i[9:0];
        CFG_DEADBAND:    cfg_q.deadband     <= cfg_data_i[13:0];
        CFG_CORR_LIMIT:  cfg_q.corr_limit   <= cfg_data_i[9:0];
        CFG_GAIN:        cfg_q.gain         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/wft_heading.sv
// Heading correction: deadband, gain multiply with rounding, saturation.
module wft_heading
  import wft_pkg::*;
(
  input  herr_t              err_i,
  input  logic [13:0]        deadband_i,
  input  logic [15:0]        gain_i,
  input  logic [9:0]         limit_i,
  output logic signed [10:0] corr_o
);

  logic [29:0] prod;
  logic [30:0] rnd;
  logic [14:0] cmag;
  logic [9:0]  sat;
  logic        active;

  // Work on the magnitude so rounding is symmetric about zero
  assign prod   = {16'b0, err_i.mag} * {14'b0, gain_i};
  assign rnd    = {1'b0, prod} + ROUND_HALF;
  assign cmag   = rnd[30:16];
  assign sat    = (cmag > {5'b0, limit_i}) ? limit_i : cmag[9:0];
  assign active = err_i.mag > deadband_i;

  always_comb begin
    if (!active) begin
      corr_o = '0;
    end else if (err_i.neg) begin
      corr_o = -$signed({1'b0, sat});
    end else begin
      corr_o = $signed({1'b0, sat});
    end
  end

endmodule

// File: rtl/wft_core.sv
// Pose and range state plus the GO / turn mode machine for control ticks.
module wft_core
  import wft_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  typedef enum logic [1:0] {
    MODE_GO    = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_LEFT  = 2'd2
  } mode_e;

  mode_e              mode_q, mode_d;
  logic               started_q;
  logic signed [15:0] cur_x_q, cur_y_q, cur_yaw_q;
  logic signed [15:0] leg_x_q, leg_y_q, turn_yaw_q;
  logic signed [15:0] leg_x_d, leg_y_d, turn_yaw_d;
  logic [15:0]        front_q, right_q, left_q;
  herr_t              err_q, err_d;

  logic signed [16:0] dx, dy;
  logic signed [33:0] sq_x, sq_y;
  logic [32:0]        dist2;
  logic               leg_done;
  logic signed [16:0] side_diff;
  logic               right_gap;
  logic               clear;
  logic signed [15:0] yaw_delta;
  logic signed [10:0] corr;
  logic [9:0]         lin;
  logic signed [10:0] ang;

  // Quadrant heading error of an incoming yaw, ties away from zero
  logic [13:0] yaw_rem;
  logic        round_up;
  assign yaw_rem  = item_i.yaw[13:0];
  assign round_up = item_i.yaw[15] ? (yaw_rem > EIGHTH) : (yaw_rem >= EIGHTH);

  always_comb begin
    if (round_up) begin
      err_d.neg = 1'b0;
      err_d.mag = 14'(QUARTER_MAG - {1'b0, yaw_rem});
    end else begin
      err_d.neg = 1'b1;
      err_d.mag = yaw_rem;
    end
  end

  // Leg distance squared against the squared leg length
  assign dx       = {cur_x_q[15], cur_x_q} - {leg_x_q[15], leg_x_q};
  assign dy       = {cur_y_q[15], cur_y_q} - {leg_y_q[15], leg_y_q};
  assign sq_x     = dx * dx;
  assign sq_y     = dy * dy;
  assign dist2    = {1'b0, sq_x[31:0]} + {1'b0, sq_y[31:0]};
  assign leg_done = dist2 >= {1'b0, cfg_i.leg_sq};

  // Range tests
  assign side_diff = {1'b0, right_q} - {1'b0, left_q};
  assign right_gap = side_diff > $signed({1'b0, cfg_i.side_margin});
  assign clear     = front_q > cfg_i.front_clear;

  // Yaw turned since the turn began, wrapped
  assign yaw_delta = cur_yaw_q - turn_yaw_q;

  wft_heading u_heading (
    .err_i      (err_q),
    .deadband_i (cfg_i.deadband),
    .gain_i     (cfg_i.gain),
    .limit_i    (cfg_i.corr_limit),
    .corr_o     (corr)
  );

  // Mode machine for one tick
  always_comb begin
    mode_d     = mode_q;
    leg_x_d    = leg_x_q;
    leg_y_d    = leg_y_q;
    turn_yaw_d = turn_yaw_q;
    lin        = '0;
    ang        = '0;
    case (mode_q)
      MODE_LEFT: begin
        if (yaw_delta < QUARTER) begin
          ang = $signed({1'b0, cfg_i.turn_rate});
        end else begin
          mode_d  = MODE_GO;
          leg_x_d = cur_x_q;
          leg_y_d = cur_y_q;
        end
      end
      MODE_RIGHT: begin
        if (yaw_delta > NEG_QUARTER) begin
          ang = -$signed({1'b0, cfg_i.turn_rate});
        end else begin
          mode_d  = MODE_GO;
          leg_x_d = cur_x_q;
          leg_y_d = cur_y_q;
        end
      end
      default: begin
        mode_d = MODE_GO;
        if (leg_done) begin
          if (right_gap && clear) begin
            mode_d     = MODE_RIGHT;
            turn_yaw_d = cur_yaw_q;
          end else if ((left_q > right_q) && !clear) begin
            mode_d     = MODE_LEFT;
            turn_yaw_d = cur_yaw_q;
          end
        end
        if (clear) begin
          lin = cfg_i.cruise_speed;
          ang = corr;
        end
      end
    endcase
  end

  assign res_o.linear_speed = lin;
  assign res_o.angular_rate = ang;
  assign res_o.drive_mode   = mode_d;

  // State update per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_GO;
      started_q  <= 1'b0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      cur_yaw_q  <= '0;
      err_q      <= '0;
      leg_x_q    <= '0;
      leg_y_q    <= '0;
      turn_yaw_q <= '0;
      front_q    <= RANGE_RST;
      right_q    <= RANGE_RST;
      left_q     <= RANGE_RST;
    end else if (fire_i) begin
      case (item_i.req)
        REQ_POSE: begin
          cur_x_q   <= item_i.pos_x;
          cur_y_q   <= item_i.pos_y;
          cur_yaw_q <= item_i.yaw;
          err_q     <= err_d;
          if (!started_q) begin
            leg_x_q    <= item_i.pos_x;
            leg_y_q    <= item_i.pos_y;
            turn_yaw_q <= item_i.yaw;
            started_q  <= 1'b1;
          end
        end
        REQ_RANGE: begin
          front_q   <= item_i.front;
          right_q   <= item_i.right;
          left_q    <= item_i.left;
          started_q <= 1'b1;
        end
        REQ_TICK: begin
          mode_q     <= mode_d;
          leg_x_q    <= leg_x_d;
          leg_y_q    <= leg_y_d;
          turn_yaw_q <= turn_yaw_d;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/wall_follow_turn_controller.sv
// A tick's command is registered in the input register and then in the output register before it
// shows on the master side; a stalled result can hold the tick in the input register.
// Throughput: one item per cycle; a tick stalls intake only while a stalled result holds it.
// Pose and range updates give no result and only pass through the input register.
// Reset (async, active low) empties both registers, restores register defaults,
// sets mode GO, clears pose and leg start, and sets all ranges to 10000 mm.
module wall_follow_turn_controller
  import wft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: pos_x_mm, pos_y_mm, yaw_angle, range_front_mm, range_right_mm, range_left_mm
  input  logic [95:0] s_axis_tdata,
  // tuser: req_type
  input  logic [1:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: linear_speed, angular_rate, drive_mode, one zero pad bit
  output logic [23:0] m_axis_tdata,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t  cfg;
  item_t in_item, in_item_q;
  logic  in_valid_q;
  res_t  res, out_res_q;
  logic  out_valid_q;
  logic  is_tick, out_free, fire;

  assign cfg_ready_o = 1'b1;

  wft_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Unpack the input transfer
  assign in_item.req   = req_e'(s_axis_tuser);
  assign in_item.pos_x = s_axis_tdata[15:0];
  assign in_item.pos_y = s_axis_tdata[31:16];
  assign in_item.yaw   = s_axis_tdata[47:32];
  assign in_item.front = s_axis_tdata[63:48];
  assign in_item.right = s_axis_tdata[79:64];
  assign in_item.left  = s_axis_tdata[95:80];

  // Handshake: only a tick needs room in the output register
  assign is_tick       = in_item_q.req == REQ_TICK;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!is_tick || out_free);
  assign s_axis_tready = !in_valid_q || fire;

  wft_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire && is_tick) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item;
    end
    if (fire && is_tick) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.drive_mode, out_res_q.angular_rate,
                          out_res_q.linear_speed};

endmodule

// File: rtl/wft_checker.sv
// Port-level checks of the wall-follow turn controller, bound to the top level.
module wft_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [15:0] cfg_data_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Only go, right and left are ever reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[22:21] != 2'd3)
    else $error("unused drive mode reported");

  // A left turn is only chosen when blocked, so it never drives forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9:0] != 10'd0 |-> m_axis_tdata[22:21] != 2'd2)
    else $error("forward speed while turning left");

  // A left turn never commands a right yaw rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22:21] == 2'd2 |-> !m_axis_tdata[20])
    else $error("left turn with negative rate");

endmodule

bind wall_follow_turn_controller wft_port_checks u_wft_checker (.*);

// File: sim/wft_checker.sv
// Drive-command checker: follows every transfer of the controller and compares its commands.
module wft_checker
  import wft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [95:0] s_data_i,
  input  logic [1:0]  s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [23:0] m_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    DRV_GO    = 2'd0,
    DRV_RIGHT = 2'd1,
    DRV_LEFT  = 2'd2
  } drive_e;

  // Settings as last written
  logic [15:0] front_clear, side_margin, leg_len, gain;
  logic [9:0]  cruise, spin_rate, corr_limit;
  logic [13:0] deadband;

  // Controller state
  drive_e             mode;
  logic               started;
  logic signed [15:0] cur_x, cur_y, cur_yaw, leg_x, leg_y, turn_yaw;
  logic [15:0]        front_rng, right_rng, left_rng;

  res_t drive_cmd_q[$];
  int   fail_cnt;

  // Snap heading to the nearest quadrant, deadband, Q16 gain, round, saturate
  function automatic logic signed [10:0] yaw_correction(logic signed [15:0] yaw);
    logic [13:0] r;
    int          err;
    longint      p, c;
    r = yaw[13:0];
    if (!yaw[15]) err = (r >= EIGHTH) ? 16384 - int'(r) : -int'(r);
    else err = (r > EIGHTH) ? 16384 - int'(r) : -int'(r);
    if ((err < 0 ? -err : err) <= int'(deadband)) return '0;
    p = longint'(err) * longint'(gain);
    if (p >= 0) c = (p + 32768) >>> 16;
    else c = -((-p + 32768) >>> 16);
    if (c > longint'(corr_limit)) c = longint'(corr_limit);
    if (c < -longint'(corr_limit)) c = -longint'(corr_limit);
    return 11'(c);
  endfunction

  // Update state for one accepted request; a tick queues its drive command
  task automatic predict_request(input req_e req, input logic [95:0] d);
    logic signed [15:0] dyaw;
    longint             dx, dy, dist2, leg2;
    int                 diff;
    logic               clear;
    res_t               cmd;
    case (req)
      REQ_POSE: begin
        cur_x = d[15:0];
        cur_y = d[31:16];
        cur_yaw = d[47:32];
        if (!started) begin
          leg_x = cur_x;
          leg_y = cur_y;
          turn_yaw = cur_yaw;
          started = 1'b1;
        end
      end
      REQ_RANGE: begin
        front_rng = d[63:48];
        right_rng = d[79:64];
        left_rng = d[95:80];
        started = 1'b1;
      end
      REQ_TICK: begin
        cmd = '0;
        if (mode == DRV_LEFT || mode == DRV_RIGHT) begin
          // turn runs until the wrapped yaw change reaches a quarter turn
          dyaw = cur_yaw - turn_yaw;
          if (mode == DRV_LEFT && dyaw < QUARTER) begin
            cmd.angular_rate = $signed({1'b0, spin_rate});
          end else if (mode == DRV_RIGHT && dyaw > NEG_QUARTER) begin
            cmd.angular_rate = -$signed({1'b0, spin_rate});
          end else begin
            mode = DRV_GO;
            leg_x = cur_x;
            leg_y = cur_y;
          end
        end else begin
          dx = longint'(cur_x) - longint'(leg_x);
          dy = longint'(cur_y) - longint'(leg_y);
          dist2 = dx * dx + dy * dy;
          leg2 = longint'(leg_len) * longint'(leg_len);
          clear = front_rng > front_clear;
          mode = DRV_GO;
          if (dist2 >= leg2) begin
            diff = int'(right_rng) - int'(left_rng);
            if (diff > int'(side_margin) && clear) begin
              mode = DRV_RIGHT;
              turn_yaw = cur_yaw;
            end else if (left_rng > right_rng && !clear) begin
              mode = DRV_LEFT;
              turn_yaw = cur_yaw;
            end
          end
          if (clear) begin
            cmd.linear_speed = cruise;
            cmd.angular_rate = yaw_correction(cur_yaw);
          end
        end
        cmd.drive_mode = mode;
        drive_cmd_q.push_back(cmd);
      end
      default: ;
    endcase
  endtask

  task automatic note_failure(input string what, input res_t want, input res_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t: %s: expected speed %0d rate %0d mode %0d, got speed %0d rate %0d mode %0d",
               $realtime, what, want.linear_speed, want.angular_rate, want.drive_mode,
               got.linear_speed, got.angular_rate, got.drive_mode);
    end
  endtask

  // Apply settings, check outputs against the oldest command, then predict
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      front_clear = FRONT_CLEAR_RST;
      side_margin = SIDE_MARGIN_RST;
      leg_len = 16'd300;
      cruise = CRUISE_RST;
      spin_rate = TURN_RATE_RST;
      deadband = DEADBAND_RST;
      corr_limit = CORR_LIMIT_RST;
      gain = GAIN_RST;
      mode = DRV_GO;
      started = 1'b0;
      cur_x = '0;
      cur_y = '0;
      cur_yaw = '0;
      leg_x = '0;
      leg_y = '0;
      turn_yaw = '0;
      front_rng = RANGE_RST;
      right_rng = RANGE_RST;
      left_rng = RANGE_RST;
      drive_cmd_q.delete();
      fail_cnt = 0;
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FRONT_CLEAR: front_clear = cfg_data_i;
          CFG_SIDE_MARGIN: side_margin = cfg_data_i;
          CFG_LEG_LENGTH:  leg_len = cfg_data_i;
          CFG_CRUISE:      cruise = cfg_data_i[9:0];
          CFG_TURN_RATE:   spin_rate = cfg_data_i[9:0];
          CFG_DEADBAND:    deadband = cfg_data_i[13:0];
          CFG_CORR_LIMIT:  corr_limit = cfg_data_i[9:0];
          CFG_GAIN:        gain = cfg_data_i;
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        got.linear_speed = m_data_i[9:0];
        got.angular_rate = m_data_i[20:10];
        got.drive_mode = m_data_i[22:21];
        if (drive_cmd_q.size() == 0) begin
          note_failure("drive command with none pending", '0, got);
        end else begin
          want = drive_cmd_q.pop_front();
          if (got.linear_speed !== want.linear_speed ||
              got.angular_rate !== want.angular_rate ||
              got.drive_mode !== want.drive_mode) begin
            note_failure("drive command mismatch", want, got);
          end
        end
      end
      if (s_valid_i && s_ready_i) predict_request(req_e'(s_user_i), s_data_i);
      pending_o = drive_cmd_q.size();
      errors_o = fail_cnt;
    end
  end

endmodule

// File: sim/tb.sv
// Testbench top: stimulus, settings phases and verdict for the wall-follow turn controller.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wft_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tdata: pos_x_mm, pos_y_mm, yaw_angle, range_front_mm, range_right_mm, range_left_mm
  logic [95:0] s_axis_tdata;
  // tuser: req_type
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tdata: linear_speed, angular_rate, drive_mode, zero pad bit
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  int errors;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;

  // Settings written so far, used to aim the random stimulus
  logic [15:0]        reg_val [8];
  logic signed [15:0] walk_x, walk_y;

  wall_follow_turn_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  wft_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #6 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Run limit
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [15:0] clamp16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic item_t noise_item(req_e req);
    item_t it;
    it.req = req;
    it.pos_x = 16'($urandom);
    it.pos_y = 16'($urandom);
    it.yaw = 16'($urandom);
    it.front = 16'($urandom);
    it.right = 16'($urandom);
    it.left = 16'($urandom);
    return it;
  endfunction

  function automatic item_t pose_item(logic signed [15:0] x, logic signed [15:0] y,
                                      logic signed [15:0] yaw);
    item_t it;
    it = noise_item(REQ_POSE);
    it.pos_x = x;
    it.pos_y = y;
    it.yaw = yaw;
    return it;
  endfunction

  function automatic item_t range_item(logic [15:0] f, logic [15:0] r, logic [15:0] l);
    item_t it;
    it = noise_item(REQ_RANGE);
    it.front = f;
    it.right = r;
    it.left = l;
    return it;
  endfunction

  // Mostly plausible motion: walk around the leg, yaw near a quadrant,
  // ranges near the clearance and side margin; the rest is noise
  function automatic item_t next_item();
    item_t it;
    int    pick, spread, lim, lft;
    pick = $urandom_range(99);
    if (pick < 4) begin
      it = noise_item(REQ_NONE);
    end else if (pick < 40) begin
      it = noise_item(REQ_POSE);
      if ($urandom_range(9) != 0) begin
        lim = int'(reg_val[CFG_LEG_LENGTH]) / 2 + 50;
        walk_x = walk_x + 16'(int'($urandom_range(2 * lim)) - lim);
        walk_y = walk_y + 16'(int'($urandom_range(2 * lim)) - lim);
        it.pos_x = walk_x;
        it.pos_y = walk_y;
        spread = ($urandom_range(9) < 3) ? 9000 : 1500;
        it.yaw = 16'(int'($urandom_range(3)) * 16384 + int'($urandom_range(2 * spread)) - spread);
      end
    end else if (pick < 65) begin
      it = noise_item(REQ_RANGE);
      if ($urandom_range(9) < 7) begin
        it.front = clamp16(int'(reg_val[CFG_FRONT_CLEAR]) + int'($urandom_range(200)) - 100);
        lft = $urandom_range(3000);
        it.left = 16'(lft);
        if ($urandom_range(1) != 0)
          it.right = clamp16(lft + int'(reg_val[CFG_SIDE_MARGIN]) +
                             int'($urandom_range(200)) - 100);
        else
          it.right = 16'($urandom_range(3000));
      end
    end else begin
      it = noise_item(REQ_TICK);
    end
    return it;
  endfunction

  // One input transfer; entered and left at a falling edge
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.left, it.right, it.front, it.yaw, it.pos_y, it.pos_x};
    s_axis_tuser <= it.req;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop sending and let every pending command and update work through
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_val[idx] = val;
  endtask

  task automatic write_settings(input int front, input int margin, input int leg,
                                input int speed, input int spin, input int band,
                                input int limit, input int k);
    write_reg(CFG_FRONT_CLEAR, 16'(front));
    write_reg(CFG_SIDE_MARGIN, 16'(margin));
    write_reg(CFG_LEG_LENGTH, 16'(leg));
    write_reg(CFG_CRUISE, 16'(speed));
    write_reg(CFG_TURN_RATE, 16'(spin));
    write_reg(CFG_DEADBAND, 16'(band));
    write_reg(CFG_CORR_LIMIT, 16'(limit));
    write_reg(CFG_GAIN, 16'(k));
  endtask

  initial begin
    item_t it;
    int    sent;
    int    idle_by_phase [5];
    int    stall_by_phase [5];
    idle_by_phase = '{0, 80, 0, 35, 0};
    stall_by_phase = '{0, 0, 80, 35, 0};
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_POSE;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FRONT_CLEAR;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    walk_x = '0;
    walk_y = '0;
    reg_val[CFG_FRONT_CLEAR] = FRONT_CLEAR_RST;
    reg_val[CFG_SIDE_MARGIN] = SIDE_MARGIN_RST;
    reg_val[CFG_LEG_LENGTH] = 16'd300;
    reg_val[CFG_CRUISE] = 16'(CRUISE_RST);
    reg_val[CFG_TURN_RATE] = 16'(TURN_RATE_RST);
    reg_val[CFG_DEADBAND] = 16'(DEADBAND_RST);
    reg_val[CFG_CORR_LIMIT] = 16'(CORR_LIMIT_RST);
    reg_val[CFG_GAIN] = GAIN_RST;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: ignored request, range before the first pose, quadrant ties
    send_item(noise_item(REQ_NONE));
    send_item(range_item(16'hFFFF, 16'd0, 16'hFFFF));
    send_item(pose_item(-16'sd32768, 16'sd32767, 16'sd8192));
    send_item(noise_item(REQ_TICK));
    send_item(pose_item(-16'sd32768, 16'sd32767, -16'sd8192));
    send_item(noise_item(REQ_TICK));
    send_item(pose_item(16'sd0, 16'sd0, 16'sd32767));
    send_item(noise_item(REQ_TICK));
    // left turn on a leg of exactly the leg length, held through a half turn
    send_item(range_item(16'd0, 16'd0, 16'd100));
    send_item(pose_item(16'sd300, 16'sd0, 16'sd0));
    send_item(noise_item(REQ_TICK));
    send_item(noise_item(REQ_TICK));
    send_item(pose_item(16'sd300, 16'sd0, -16'sd32768));
    send_item(noise_item(REQ_TICK));
    send_item(pose_item(-16'sd300, 16'sd5, 16'sd16384));
    send_item(noise_item(REQ_TICK));
    // right turn ended by a yaw change of minus a half turn
    send_item(range_item(16'hFFFF, 16'hFFFF, 16'd0));
    send_item(pose_item(16'sd32767, -16'sd32768, -16'sd16384));
    send_item(noise_item(REQ_TICK));
    send_item(noise_item(REQ_TICK));
    send_item(pose_item(16'sd32767, -16'sd32768, 16'sd16384));
    send_item(noise_item(REQ_TICK));
    send_item(noise_item(REQ_TICK));

    // Random phases, each under its own settings and idling pattern
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: write_settings(450, 200, 300, 200, 250, 364, 150, 1885);
        1: write_settings(65535, 65535, 65535, 1000, 1000, 8192, 1000, 65535);
        2: write_settings(0, 0, 0, 0, 0, 0, 0, 0);
        default: write_settings($urandom_range(100, 1500), $urandom_range(800),
                                $urandom_range(2000), $urandom_range(1000),
                                $urandom_range(1000), $urandom_range(8192),
                                $urandom_range(1000), $urandom_range(65535));
      endcase
      send_idle_pct = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      sent = 0;
      while (sent < 320) begin
        it = next_item();
        send_item(it);
        if (it.req != REQ_NONE) sent++;
      end
    end

    drain();
    repeat (6) @(negedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/wft_pkg.sv
rtl/wft_cfg_regs.sv
rtl/wft_heading.sv
rtl/wft_core.sv
rtl/wall_follow_turn_controller.sv
rtl/wft_checker.sv
sim/wft_checker.sv
sim/tb.sv
